[design/wus_pkg.sv]
// Package for the windowed usage statistics unit: word types, op codes and widths.
// Used by wus_div and windowed_usage_statistics_unit; depends on nothing else.
`timescale 1ns / 1ps

package wus_pkg;

    // Width of the running signed memory sum.
    localparam int SUM_BITS = 48;
    // Width of the divider step counter, able to hold SUM_BITS itself.
    localparam int CNT_BITS = $clog2(SUM_BITS + 1);

    localparam logic [31:0] SIGNED_WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SIGNED_WORD_MIN = 32'h8000_0000;
    localparam logic [31:0] WINDOW_TICKS_RESET = 32'd1000;

    // Op codes of an input word.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_CLOSE  = 2'd2;

    // Status codes of a result word.
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        cycles;
        logic signed [31:0] memory;
        logic [31:0]        now;
        logic signed [31:0] cur_mem;
    } item_t;

    typedef struct packed {
        logic               status;
        logic               window_closed;
        logic [31:0]        last_cycles;
        logic [31:0]        last_switches;
        logic signed [31:0] last_mean;
        logic signed [31:0] last_min;
        logic signed [31:0] last_max;
        logic [31:0]        window_stamp;
    } result_t;

endpackage

[design/windowed_usage_statistics_unit.sv]
// Top level of the windowed usage statistics unit: sequencer, accumulators and result word.
// Depends on wus_pkg and instantiates wus_div for the window mean.
//
//   Channel   Signals                          Direction  Word
//   item      item_valid, item_ready, item     in         item_t
//   result    result_valid, result_ready, result out      result_t
//   config    cfg_we, cfg_data                 in         window length in ticks
//
// A sample, tick, refused close or close of an empty window passes through the execute
// and push states after acceptance; the push waits while an earlier result is not taken.
// An accepted close with samples also waits in the divide state for the bit-serial
// divider that forms the mean. One word is in work at a time; the next word is taken
// once the result is in the output register, even while it waits. Reset clears all
// statistics; a stalled result only delays the following word.
`timescale 1ns / 1ps

module windowed_usage_statistics_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  wus_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output wus_pkg::result_t result,
    input  logic             cfg_we,
    input  logic [31:0]      cfg_data
);
    import wus_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_PUSH
    } state_t;

    state_t              state_reg, state_next;
    item_t               item_reg;
    logic [31:0]         window_ticks_reg;
    logic [31:0]         cycle_sum_reg, cycle_sum_next;
    logic [31:0]         sample_count_reg, sample_count_next;
    logic [SUM_BITS-1:0] mem_sum_reg, mem_sum_next;
    logic signed [31:0]  mem_min_reg, mem_min_next;
    logic signed [31:0]  mem_max_reg, mem_max_next;
    logic [31:0]         deadline_reg, deadline_next;
    logic                closed_reg, closed_next;
    logic [31:0]         stamp_reg, stamp_next;
    logic                status_reg, status_next;
    logic                neg_reg, neg_next;
    logic [31:0]         last_cycles_reg, last_cycles_next;
    logic [31:0]         last_switches_reg, last_switches_next;
    logic signed [31:0]  last_mean_reg, last_mean_next;
    logic signed [31:0]  last_min_reg, last_min_next;
    logic signed [31:0]  last_max_reg, last_max_next;
    logic                result_valid_reg, result_valid_next;
    result_t             result_reg, result_next;

    logic                div_start;
    logic                div_done;
    logic [SUM_BITS-1:0] div_quotient;
    logic [SUM_BITS-1:0] sum_mag;
    logic [SUM_BITS-1:0] mem_ext;
    logic                quo_big;
    logic [31:0]         mean_sat;

    // Divider for the mean of the window.
    wus_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (sample_count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Magnitude of the signed sum and saturation of the signed quotient.
    always_comb
    begin
        sum_mag  = mem_sum_reg[SUM_BITS-1] ? (-mem_sum_reg) : mem_sum_reg;
        mem_ext  = SUM_BITS'(item_reg.memory);
        quo_big  = |div_quotient[SUM_BITS-1:31];
        if (neg_reg)
            mean_sat = quo_big ? SIGNED_WORD_MIN : (-div_quotient[31:0]);
        else
            mean_sat = quo_big ? SIGNED_WORD_MAX : div_quotient[31:0];
    end

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next         = state_reg;
        cycle_sum_next     = cycle_sum_reg;
        sample_count_next  = sample_count_reg;
        mem_sum_next       = mem_sum_reg;
        mem_min_next       = mem_min_reg;
        mem_max_next       = mem_max_reg;
        deadline_next      = deadline_reg;
        closed_next        = closed_reg;
        stamp_next         = stamp_reg;
        status_next        = status_reg;
        neg_next           = neg_reg;
        last_cycles_next   = last_cycles_reg;
        last_switches_next = last_switches_reg;
        last_mean_next     = last_mean_reg;
        last_min_next      = last_min_reg;
        last_max_next      = last_max_reg;
        result_valid_next  = result_valid_reg;
        result_next        = result_reg;
        div_start          = 1'b0;

        // The consumer takes the waiting result word.
        if (result_valid_reg && result_ready)
            result_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                status_next = STATUS_OK;
                state_next  = ST_PUSH;
                case (item_reg.op)
                    OP_SAMPLE:
                    begin
                        cycle_sum_next    = cycle_sum_reg + item_reg.cycles;
                        sample_count_next = sample_count_reg + 32'd1;
                        mem_sum_next      = mem_sum_reg + mem_ext;
                        if (item_reg.memory < mem_min_reg)
                            mem_min_next = item_reg.memory;
                        if (item_reg.memory > mem_max_reg)
                            mem_max_next = item_reg.memory;
                    end
                    OP_TICK:
                    begin
                        closed_next = 1'b0;
                        // Deadline reached: advance by one window, which keeps the
                        // grid fixed however late the tick comes.
                        if (!(deadline_reg > item_reg.now))
                        begin
                            if (deadline_reg != 32'd0)
                                closed_next = 1'b1;
                            deadline_next = deadline_reg + window_ticks_reg;
                            stamp_next    = item_reg.now;
                        end
                    end
                    OP_CLOSE:
                    begin
                        if (!closed_reg)
                        begin
                            status_next = STATUS_REFUSED;
                        end
                        else
                        begin
                            last_cycles_next   = cycle_sum_reg;
                            last_switches_next = sample_count_reg;
                            if (sample_count_reg != 32'd0)
                            begin
                                last_min_next = mem_min_reg;
                                last_max_next = mem_max_reg;
                                neg_next      = mem_sum_reg[SUM_BITS-1];
                                div_start     = 1'b1;
                                state_next    = ST_DIV;
                            end
                            else
                            begin
                                last_mean_next = item_reg.cur_mem;
                                last_min_next  = item_reg.cur_mem;
                                last_max_next  = item_reg.cur_mem;
                            end
                            cycle_sum_next    = '0;
                            sample_count_next = '0;
                            mem_sum_next      = '0;
                            mem_min_next      = SIGNED_WORD_MAX;
                            mem_max_next      = SIGNED_WORD_MIN;
                        end
                    end
                    default:
                    begin
                        status_next = STATUS_OK;
                    end
                endcase
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    last_mean_next = mean_sat;
                    state_next     = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.status        = status_reg;
                    result_next.window_closed = closed_reg;
                    result_next.last_cycles   = last_cycles_reg;
                    result_next.last_switches = last_switches_reg;
                    result_next.last_mean     = last_mean_reg;
                    result_next.last_min      = last_min_reg;
                    result_next.last_max      = last_max_reg;
                    result_next.window_stamp  = stamp_reg;
                    result_valid_next         = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, statistics and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            window_ticks_reg  <= WINDOW_TICKS_RESET;
            cycle_sum_reg     <= '0;
            sample_count_reg  <= '0;
            mem_sum_reg       <= '0;
            mem_min_reg       <= SIGNED_WORD_MAX;
            mem_max_reg       <= SIGNED_WORD_MIN;
            deadline_reg      <= '0;
            closed_reg        <= 1'b0;
            stamp_reg         <= '0;
            status_reg        <= STATUS_OK;
            neg_reg           <= 1'b0;
            last_cycles_reg   <= '0;
            last_switches_reg <= '0;
            last_mean_reg     <= '0;
            last_min_reg      <= '0;
            last_max_reg      <= '0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            if (cfg_we)
                window_ticks_reg <= cfg_data;
            cycle_sum_reg     <= cycle_sum_next;
            sample_count_reg  <= sample_count_next;
            mem_sum_reg       <= mem_sum_next;
            mem_min_reg       <= mem_min_next;
            mem_max_reg       <= mem_max_next;
            deadline_reg      <= deadline_next;
            closed_reg        <= closed_next;
            stamp_reg         <= stamp_next;
            status_reg        <= status_next;
            neg_reg           <= neg_next;
            last_cycles_reg   <= last_cycles_next;
            last_switches_reg <= last_switches_next;
            last_mean_reg     <= last_mean_next;
            last_min_reg      <= last_min_next;
            last_max_reg      <= last_max_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    // Payload registers for the accepted word and the result word.
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
        result_reg <= result_next;
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    // An accepted word is executed in the following cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted word not executed");

    // The divider finishes only while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    // A division is never started with a zero sample count.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (sample_count_reg != 32'd0))
        else $error("division started with zero divisor");
`endif

endmodule

[design/wus_div.sv]
// Restoring unsigned divider for the window mean: one quotient bit per cycle.
// Depends on wus_pkg for SUM_BITS and CNT_BITS.
`timescale 1ns / 1ps

module wus_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [wus_pkg::SUM_BITS-1:0] dividend,
    input  logic [31:0]                  divisor,
    output logic                         done,
    output logic [wus_pkg::SUM_BITS-1:0] quotient
);
    import wus_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [31:0]         rem_reg;
    logic [31:0]         divisor_reg;
    logic [SUM_BITS-1:0] quo_reg;

    logic [32:0]         rem_shift;
    logic [32:0]         rem_diff;
    logic                fits;

    // One shift, compare and subtract step of the restoring division.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[SUM_BITS-1]};
        rem_diff  = rem_shift - {1'b0, divisor_reg};
        fits      = (rem_shift >= {1'b0, divisor_reg});
    end

    // Step sequencer: load on start, then SUM_BITS steps, then a done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(SUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_diff[31:0] : rem_shift[31:0];
            quo_reg <= {quo_reg[SUM_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
